// ----- rtl/epi_pkg.sv -----
// Package: item types, command codes, sequencer types and the axis-update program.
package epi_pkg;

  // Command codes
  localparam logic [2:0] OP_TIMED    = 3'd0;
  localparam logic [2:0] OP_DIST     = 3'd1;
  localparam logic [2:0] OP_ADD_ANG  = 3'd2;
  localparam logic [2:0] OP_SET_ANGS = 3'd3;
  localparam logic [2:0] OP_SET_ANG  = 3'd4;
  localparam logic [2:0] OP_SET_POS  = 3'd5;

  // Move directions and angle selectors
  localparam logic [2:0] DIR_FRONT = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_BACK  = 3'd3;
  localparam logic [2:0] DIR_DOWN  = 3'd5;
  localparam logic [2:0] ANG_ROLL  = 3'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPEED   = 2'd0;
  localparam logic [1:0] CFG_MOVABLE = 2'd1;

  // Axis vector base indexes (right, up, front)
  localparam logic [3:0] AX_RIGHT = 4'd0;
  localparam logic [3:0] AX_UP    = 4'd3;
  localparam logic [3:0] AX_FRONT = 4'd6;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [15:0] SPEED_RESET = 16'd64;
  localparam logic [4:0] MAT_LAST = 5'd17;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         direction;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_TRIG_WAIT,
    ST_MAT,
    ST_MV_MUL1,
    ST_MV_MUL2,
    ST_MV_RND,
    ST_MV_ACC,
    ST_FIN
  } state_t;

  // Operand sources of the shared multiplier (trig values in cordic order)
  typedef enum logic [2:0] {
    SRC_CP, SRC_SP, SRC_CY, SRC_SY, SRC_CR, SRC_SR, SRC_P
  } src_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_LD, ACC_LDN, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_SR, WR_R2, WR_R3} wr_op_t;

  // One step of the axis-update program
  typedef struct packed {
    logic    mul;
    src_t    a;
    src_t    b;
    acc_op_t acc;
    wr_op_t  wr;
    logic [3:0] idx;
  } mstep_t;

  // Arctangent table, 2^32 units per turn
  function automatic logic signed [32:0] atan_val(input logic [4:0] i);
    logic signed [32:0] v;
    case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  // Clamp to [-1.0, 1.0] in Q2.14
  function automatic logic signed [15:0] clamp_q14(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd16384) r = ONE_Q14;
    else if (v < -48'sd16384) r = -ONE_Q14;
    else r = v[15:0];
    return r;
  endfunction

  // Axis-update program: multiply, accumulate and write overlap across steps
  function automatic mstep_t mat_step(input logic [4:0] s);
    mstep_t m;
    m = '{mul: 1'b0, a: SRC_CP, b: SRC_CP, acc: ACC_NONE, wr: WR_NONE, idx: 4'd0};
    case (s)
      5'd0:  begin m.mul = 1'b1; m.a = SRC_CY; m.b = SRC_CR; end
      5'd1:  begin
        m.mul = 1'b1; m.a = SRC_SY; m.b = SRC_CR; m.acc = ACC_LD; m.wr = WR_SR; m.idx = 4'd1;
      end
      5'd2:  begin
        m.mul = 1'b1; m.a = SRC_CR; m.b = SRC_CP; m.acc = ACC_LDN; m.wr = WR_R2; m.idx = 4'd0;
      end
      5'd3:  begin
        m.mul = 1'b1; m.a = SRC_CR; m.b = SRC_SP; m.acc = ACC_LD; m.wr = WR_R2; m.idx = 4'd2;
      end
      5'd4:  begin
        m.mul = 1'b1; m.a = SRC_CY; m.b = SRC_SR; m.acc = ACC_LDN; m.wr = WR_R2; m.idx = 4'd4;
      end
      5'd5:  begin m.mul = 1'b1; m.a = SRC_P; m.b = SRC_CP; m.wr = WR_R2; m.idx = 4'd7; end
      5'd6:  begin m.mul = 1'b1; m.a = SRC_SY; m.b = SRC_SP; m.acc = ACC_LDN; end
      5'd7:  begin m.mul = 1'b1; m.a = SRC_SY; m.b = SRC_SR; m.acc = ACC_ADD; end
      5'd8:  begin m.mul = 1'b1; m.a = SRC_P; m.b = SRC_CP; m.wr = WR_R3; m.idx = 4'd3; end
      5'd9:  begin m.mul = 1'b1; m.a = SRC_CY; m.b = SRC_SP; m.acc = ACC_LD; end
      5'd10: begin m.mul = 1'b1; m.a = SRC_CY; m.b = SRC_SR; m.acc = ACC_ADD; end
      5'd11: begin m.mul = 1'b1; m.a = SRC_P; m.b = SRC_SP; m.wr = WR_R3; m.idx = 4'd5; end
      5'd12: begin m.mul = 1'b1; m.a = SRC_SY; m.b = SRC_CP; m.acc = ACC_LD; end
      5'd13: begin m.mul = 1'b1; m.a = SRC_SY; m.b = SRC_SR; m.acc = ACC_ADD; end
      5'd14: begin m.mul = 1'b1; m.a = SRC_P; m.b = SRC_SP; m.wr = WR_R3; m.idx = 4'd6; end
      5'd15: begin m.mul = 1'b1; m.a = SRC_CY; m.b = SRC_CP; m.acc = ACC_LDN; end
      5'd16: begin m.acc = ACC_ADD; end
      5'd17: begin m.wr = WR_R3; m.idx = 4'd8; end
      default: ;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/epi_cordic.sv -----
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.14 sine and cosine out.
module epi_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [15:0] cos_v,
  output logic signed [15:0] sin_v
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic signed [33:0] CORDIC_GAIN_Q30_L = epi_pkg::CORDIC_GAIN_Q30;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;
  logic [IW-1:0]      i;
  logic               flip;
  logic               busy;

  logic signed [15:0] a16;
  logic signed [16:0] zp;
  logic               fl;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic               last;
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [15:0] xc;
  logic signed [15:0] yc;

  // Fold the angle into the right half plane
  always_comb begin
    a16 = angle;
    zp  = 17'(a16);
    fl  = 1'b0;
    if (a16 >= 16'sd16384) begin
      zp = 17'(a16) - 17'sd32768;
      fl = 1'b1;
    end else if (a16 < -16'sd16384) begin
      zp = 17'(a16) + 17'sd32768;
      fl = 1'b1;
    end
  end

  assign dx   = y >>> i;
  assign dy   = x >>> i;
  assign last = (i == IW'(CORDIC_STEPS - 1));

  // Load on start, then rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      x    <= CORDIC_GAIN_Q30_L;
      y    <= '0;
      z    <= {zp, 16'b0};
      i    <= '0;
      flip <= fl;
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - epi_pkg::atan_val(5'(i));
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + epi_pkg::atan_val(5'(i));
      end
      i <= i + IW'(1);
    end
  end

  // Round to Q2.14, clamp, undo the fold
  always_comb begin
    xr = (x + 34'sd32768) >>> 16;
    yr = (y + 34'sd32768) >>> 16;
    xc = epi_pkg::clamp_q14(48'(xr));
    yc = epi_pkg::clamp_q14(48'(yr));
    cos_v = flip ? -xc : xc;
    sin_v = flip ? -yc : yc;
  end

endmodule

// ----- rtl/epi_mul.sv -----
// Shared signed multiplier with a registered product.
module epi_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [63:0] prod
);

  logic signed [65:0] full;

  assign full = a * b;

  // Hold the product until the next enabled step
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[63:0];
    end
  end

endmodule

// ----- rtl/euler_pose_integrator.sv -----
// Top level: pose registers, command sequencer, shared multiplier and CORDIC.
//
//   channel  signals                          direction  item
//   in       in_valid, in_stall, in_item      to block   one pose command
//   out      out_valid, out_stall, out_item   from block position and axis vectors
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write
//
// Angle commands run the CORDIC once for each of the three angles, then 18 steps of
// the shared multiplier rebuild the axes. Timed moves multiply each axis by speed and
// then by the value, distance moves by the value only; other commands go to the result.
// rst is synchronous: pose to origin with identity axes, speed 1.0, movable set.
// in_stall stays high while a command is at work; out_stall only delays the final load.
module euler_pose_integrator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  epi_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output epi_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  epi_pkg::state_t state;
  epi_pkg::state_t state_next;

  logic [15:0]        speed;
  logic               movable;
  logic [15:0]        ang [3];
  logic signed [31:0] pos [3];
  logic signed [15:0] vec [9];
  logic signed [15:0] trig [6];
  logic signed [47:0] acc;
  logic signed [47:0] step_d;
  logic [4:0]         cnt;
  logic [1:0]         tidx;
  logic [1:0]         mv_k;
  logic [3:0]         mv_base;
  logic               mv_neg;
  logic               mv_timed;
  logic signed [31:0] vx;

  logic               accept;
  logic               out_load;
  epi_pkg::mstep_t    ms;
  logic               mul_en;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [63:0] prod;
  logic               cor_start;
  logic               cor_done;
  logic signed [15:0] cor_cos;
  logic signed [15:0] cor_sin;
  logic signed [15:0] axis;
  logic [2:0]         bdir;
  logic signed [63:0] rnd;
  logic signed [48:0] psum;
  logic signed [31:0] psat;
  logic signed [47:0] r2v;
  logic signed [47:0] r3v;

  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == epi_pkg::ST_FIN) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;
  assign ms        = epi_pkg::mat_step(cnt);
  assign axis      = vec[mv_base + {2'b00, mv_k}];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      epi_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = epi_pkg::ST_FIN;
          unique case (in_item.op) inside
            epi_pkg::OP_TIMED: begin
              if (movable && in_item.direction <= epi_pkg::DIR_DOWN)
                state_next = epi_pkg::ST_MV_MUL1;
            end
            epi_pkg::OP_DIST: begin
              if (in_item.direction <= epi_pkg::DIR_DOWN) state_next = epi_pkg::ST_MV_MUL1;
            end
            epi_pkg::OP_ADD_ANG, epi_pkg::OP_SET_ANG: begin
              if (in_item.direction <= epi_pkg::ANG_ROLL) state_next = epi_pkg::ST_TRIG;
            end
            epi_pkg::OP_SET_ANGS: state_next = epi_pkg::ST_TRIG;
            default: ;
          endcase
        end
      end
      epi_pkg::ST_TRIG:      state_next = epi_pkg::ST_TRIG_WAIT;
      epi_pkg::ST_TRIG_WAIT: begin
        if (cor_done) state_next = (tidx == 2'd2) ? epi_pkg::ST_MAT : epi_pkg::ST_TRIG;
      end
      epi_pkg::ST_MAT: begin
        if (cnt == epi_pkg::MAT_LAST) state_next = epi_pkg::ST_FIN;
      end
      epi_pkg::ST_MV_MUL1: state_next = mv_timed ? epi_pkg::ST_MV_MUL2 : epi_pkg::ST_MV_RND;
      epi_pkg::ST_MV_MUL2: state_next = epi_pkg::ST_MV_RND;
      epi_pkg::ST_MV_RND:  state_next = epi_pkg::ST_MV_ACC;
      epi_pkg::ST_MV_ACC:  state_next = (mv_k == 2'd2) ? epi_pkg::ST_FIN : epi_pkg::ST_MV_MUL1;
      epi_pkg::ST_FIN: begin
        if (out_load) state_next = epi_pkg::ST_IDLE;
      end
      default: state_next = epi_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operands
  always_comb begin
    in_stall  = (state != epi_pkg::ST_IDLE);
    cor_start = (state == epi_pkg::ST_TRIG);
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      epi_pkg::ST_MAT: begin
        mul_en = ms.mul;
        mul_a  = (ms.a == epi_pkg::SRC_P) ? prod[32:0] : 33'(trig[3'(ms.a)]);
        mul_b  = 33'(trig[3'(ms.b)]);
      end
      epi_pkg::ST_MV_MUL1: begin
        mul_en = 1'b1;
        mul_a  = mv_timed ? $signed({17'b0, speed}) : 33'(vx);
        mul_b  = 33'(axis);
      end
      epi_pkg::ST_MV_MUL2: begin
        mul_en = 1'b1;
        mul_a  = prod[32:0];
        mul_b  = 33'(vx);
      end
      default: ;
    endcase
  end

  // Move arithmetic: round the step, then add with saturation; also round the axis accumulator
  always_comb begin
    bdir = (in_item.direction >= epi_pkg::DIR_BACK) ?
           in_item.direction - epi_pkg::DIR_BACK : in_item.direction;
    rnd  = mv_timed ? ((prod + 64'sd524288) >>> 20) : ((prod + 64'sd8192) >>> 14);
    psum = mv_neg ? (49'(pos[mv_k]) - 49'(step_d)) : (49'(pos[mv_k]) + 49'(step_d));
    if (psum > 49'sd2147483647) psat = 32'sh7fffffff;
    else if (psum < -49'sd2147483648) psat = 32'sh80000000;
    else psat = psum[31:0];
    r2v = (acc + 48'sd8192) >>> 14;
    r3v = (acc + 48'sd134217728) >>> 28;
  end

  // Pose state, sequencer counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= epi_pkg::ST_IDLE;
      speed   <= epi_pkg::SPEED_RESET;
      movable <= 1'b1;
      for (int k = 0; k < 3; k++) begin
        pos[k] <= '0;
        ang[k] <= '0;
      end
      for (int k = 0; k < 9; k++) begin
        vec[k] <= (k % 4 == 0) ? epi_pkg::ONE_Q14 : 16'sd0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          epi_pkg::CFG_SPEED:   speed   <= cfg_data;
          epi_pkg::CFG_MOVABLE: movable <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        epi_pkg::ST_IDLE: begin
          tidx <= 2'd0;
          cnt  <= '0;
          mv_k <= 2'd0;
          if (accept) begin
            vx       <= in_item.value_x;
            mv_timed <= (in_item.op == epi_pkg::OP_TIMED);
            mv_neg   <= (in_item.direction >= epi_pkg::DIR_BACK);
            mv_base  <= (bdir == epi_pkg::DIR_FRONT) ? epi_pkg::AX_FRONT :
                        (bdir == epi_pkg::DIR_RIGHT) ? epi_pkg::AX_RIGHT : epi_pkg::AX_UP;
            unique case (in_item.op)
              epi_pkg::OP_ADD_ANG: begin
                if (in_item.direction <= epi_pkg::ANG_ROLL)
                  ang[in_item.direction[1:0]] <= ang[in_item.direction[1:0]] +
                                                 in_item.value_x[15:0];
              end
              epi_pkg::OP_SET_ANG: begin
                if (in_item.direction <= epi_pkg::ANG_ROLL)
                  ang[in_item.direction[1:0]] <= in_item.value_x[15:0];
              end
              epi_pkg::OP_SET_ANGS: begin
                ang[0] <= in_item.value_x[15:0];
                ang[1] <= in_item.value_y[15:0];
                ang[2] <= in_item.value_z[15:0];
              end
              epi_pkg::OP_SET_POS: begin
                pos[0] <= in_item.value_x;
                pos[1] <= in_item.value_y;
                pos[2] <= in_item.value_z;
              end
              default: ;
            endcase
          end
        end
        epi_pkg::ST_TRIG_WAIT: begin
          if (cor_done) begin
            trig[{tidx, 1'b0}] <= cor_cos;
            trig[{tidx, 1'b1}] <= cor_sin;
            tidx <= tidx + 2'd1;
          end
        end
        epi_pkg::ST_MAT: begin
          cnt <= cnt + 5'd1;
          case (ms.acc)
            epi_pkg::ACC_LD:  acc <= prod[47:0];
            epi_pkg::ACC_LDN: acc <= -prod[47:0];
            epi_pkg::ACC_ADD: acc <= acc + {prod[33:0], 14'b0};
            default: ;
          endcase
          case (ms.wr)
            epi_pkg::WR_SR: vec[ms.idx] <= trig[3'(epi_pkg::SRC_SR)];
            epi_pkg::WR_R2: vec[ms.idx] <= epi_pkg::clamp_q14(r2v);
            epi_pkg::WR_R3: vec[ms.idx] <= epi_pkg::clamp_q14(r3v);
            default: ;
          endcase
        end
        epi_pkg::ST_MV_RND: step_d <= rnd[47:0];
        epi_pkg::ST_MV_ACC: begin
          pos[mv_k] <= psat;
          mv_k      <= mv_k + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Result register: load when the slot is free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_item.pos_x   <= pos[0];
      out_item.pos_y   <= pos[1];
      out_item.pos_z   <= pos[2];
      out_item.right_x <= vec[0];
      out_item.right_y <= vec[1];
      out_item.right_z <= vec[2];
      out_item.up_x    <= vec[3];
      out_item.up_y    <= vec[4];
      out_item.up_z    <= vec[5];
      out_item.front_x <= vec[6];
      out_item.front_y <= vec[7];
      out_item.front_z <= vec[8];
    end
  end

  epi_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (ang[tidx]),
    .done  (cor_done),
    .cos_v (cor_cos),
    .sin_v (cor_sin)
  );

  epi_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

endmodule
